// ===== hw/rtl/cib_pkg.sv =====
`default_nettype none

package cib_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int LEN_W        = 30;

    localparam logic [1:0] OP_LOAD_SEG   = 2'd0;
    localparam logic [1:0] OP_TABLE_BYTE = 2'd1;
    localparam logic [1:0] OP_RESTART    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT   = 2'd2;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] length;
        logic [1:0]       ctype;
    } ptr_result_t;

    typedef struct packed {
        logic [1:0]       chunk_type;
        logic [LEN_W-1:0] chunk_length;
        logic [31:0]      stream_offset;
        logic [31:0]      segment_offset;
        logic [SEG_W-1:0] segment_number;
        logic [31:0]      chunk_number;
        logic             last_chunk;
    } result_t;

    // inverted signature byte for a table position
    function automatic logic [7:0] key_byte(input logic [1:0] phase);
        logic [7:0] sig;
        case (phase)
            2'd0:    sig = 8'h49;
            2'd1:    sig = 8'h73;
            2'd2:    sig = 8'h5A;
            default: sig = 8'h21;
        endcase
        return ~sig;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cib_in_if.sv =====
`default_nettype none

interface cib_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  seg_slot;
    logic [31:0] seg_first_chunk;
    logic [31:0] seg_chunk_total;
    logic [7:0]  table_byte;

    modport source (
        output valid, opcode, seg_slot, seg_first_chunk, seg_chunk_total, table_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, seg_slot, seg_first_chunk, seg_chunk_total, table_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/cib_out_if.sv =====
`default_nettype none

interface cib_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  chunk_type;
    logic [29:0] chunk_length;
    logic [31:0] stream_offset;
    logic [31:0] segment_offset;
    logic [3:0]  segment_number;
    logic [31:0] chunk_number;
    logic        last_chunk;

    modport source (
        output valid, chunk_type, chunk_length, stream_offset, segment_offset,
               segment_number, chunk_number, last_chunk,
        input  ready
    );
    modport sink (
        input  valid, chunk_type, chunk_length, stream_offset, segment_offset,
               segment_number, chunk_number, last_chunk,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/cib_ptr_asm.sv =====
`default_nettype none

module cib_ptr_asm (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_en,
    input  wire logic                 restart,
    input  wire logic [7:0]           table_byte,
    input  wire logic [2:0]           pointer_bytes,
    output cib_pkg::ptr_result_t      ptr
);

    logic [1:0]  key_phase_reg, key_phase_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] acc_reg, acc_next;

    logic [7:0]  plain;
    logic [2:0]  width;
    logic [31:0] acc_full;
    logic        last;

    always_comb
    begin
        plain = table_byte ^ cib_pkg::key_byte(key_phase_reg);
        if (pointer_bytes == 3'd0)
            width = 3'd1;
        else if (pointer_bytes > 3'd4)
            width = 3'd4;
        else
            width = pointer_bytes;
        acc_full = acc_reg | ({24'd0, plain} << {bip_reg, 3'b000});
        last     = ({1'b0, bip_reg} + 3'd1) >= width;
    end

    always_comb
    begin
        ptr.done = byte_en && last;
        case (width)
            3'd1:
            begin
                ptr.length = {24'd0, acc_full[5:0]};
                ptr.ctype  = acc_full[7:6];
            end
            3'd2:
            begin
                ptr.length = {16'd0, acc_full[13:0]};
                ptr.ctype  = acc_full[15:14];
            end
            3'd3:
            begin
                ptr.length = {8'd0, acc_full[21:0]};
                ptr.ctype  = acc_full[23:22];
            end
            default:
            begin
                ptr.length = acc_full[29:0];
                ptr.ctype  = acc_full[31:30];
            end
        endcase
    end

    always_comb
    begin
        key_phase_next = key_phase_reg;
        bip_next       = bip_reg;
        acc_next       = acc_reg;
        if (restart)
        begin
            key_phase_next = 2'd0;
            bip_next       = 2'd0;
            acc_next       = 32'd0;
        end
        else if (byte_en)
        begin
            key_phase_next = key_phase_reg + 2'd1;
            if (last)
            begin
                bip_next = 2'd0;
                acc_next = 32'd0;
            end
            else
            begin
                bip_next = bip_reg + 2'd1;
                acc_next = acc_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_phase_reg <= 2'd0;
            bip_reg       <= 2'd0;
            acc_reg       <= 32'd0;
        end
        else
        begin
            key_phase_reg <= key_phase_next;
            bip_reg       <= bip_next;
            acc_reg       <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cib_seg_lookup.sv =====
`default_nettype none

module cib_seg_lookup (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [3:0]                wr_slot,
    input  wire logic [31:0]               wr_first,
    input  wire logic [31:0]               wr_total,
    input  wire logic [4:0]                segment_count,
    input  wire logic [31:0]               idx,
    output logic [cib_pkg::SEG_W-1:0]      seg
);

    logic [31:0] first_reg [cib_pkg::MAX_SEGMENTS];
    logic [31:0] total_reg [cib_pkg::MAX_SEGMENTS];
    logic [cib_pkg::MAX_SEGMENTS-1:0] hit;

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_slot) < 32'(cib_pkg::MAX_SEGMENTS)))
        begin
            first_reg[wr_slot] <= wr_first;
            total_reg[wr_slot] <= wr_total;
        end
    end

    // all entries compared in parallel, highest matching slot wins
    always_comb
    begin
        for (int s = 0; s < cib_pkg::MAX_SEGMENTS; s++)
        begin
            hit[s] = (32'(s) < 32'(segment_count)) && (idx >= first_reg[s]) &&
                     ((idx - first_reg[s]) < total_reg[s]);
        end
        seg = '0;
        for (int s = 0; s < cib_pkg::MAX_SEGMENTS; s++)
        begin
            if (hit[s])
                seg = cib_pkg::SEG_W'(s);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cib_out_buf.sv =====
`default_nettype none

module cib_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cib_pkg::result_t  push_data,
    output logic                   space,
    output logic                   valid,
    input  wire logic              ready,
    output cib_pkg::result_t       data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    cib_pkg::result_t main_data_reg, main_data_next;
    cib_pkg::result_t skid_data_reg, skid_data_next;
    logic             pop;

    assign pop   = main_valid_reg && ready;
    assign space = !skid_valid_reg;
    assign valid = main_valid_reg;
    assign data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a request while the output stage is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && main_valid_reg && !ready && !skid_valid_reg) |=> skid_valid_reg)
        else $error("request lost on a stalled output");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid did not move to the output stage");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && ready) |=> (main_data_reg == $past(skid_data_reg)))
        else $error("skid request out of order");

endmodule

`default_nettype wire

// ===== hw/rtl/chunk_index_builder_core.sv =====
// Chunk index builder.
// in_ch carries one request per cycle while ready is high: opcode 0 loads a
// segment table entry (seg_slot, seg_first_chunk, seg_chunk_total), 1
// delivers one raw chunk table byte, 2 restarts the index, 3 is a no-op.
// out_ch carries one index entry each time the last byte of a chunk pointer
// arrives: type, length, stream offset, segment offset, segment number,
// chunk number and a last-chunk flag.
// Config: cfg_we/cfg_index/cfg_wdata write pointer_bytes (0), segment_count
// (1) and chunk_count (2); write only while no entry is pending.
// The final byte's entry is registered into the output register or skid.
// Throughput: one request per cycle while ready is high, set by the single
// pass of pointer assembly, 16-way segment compare and offset adders
// between the input state and the output register.
// A two-entry output stage (register plus skid) lets in_ch keep accepting
// while a result waits; in_ch.ready drops only when both entries are full.
// Reset clears all counters and the output stage; config returns to 3/1/1.
// Segment table entries are undefined until loaded.
`default_nettype none

module chunk_index_builder_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [cib_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cib_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    cib_in_if.sink                                 in_ch,
    cib_out_if.source                              out_ch
);

    logic [2:0]  pointer_bytes_reg;
    logic [4:0]  segment_count_reg;
    logic [31:0] chunk_count_reg;

    logic [31:0]               next_chunk_reg, next_chunk_next;
    logic [31:0]               run_off_reg, run_off_next;
    logic [31:0]               seg_off_reg, seg_off_next;
    logic [cib_pkg::SEG_W-1:0] highest_reg, highest_next;

    logic                      accept;
    logic                      byte_en;
    logic                      restart;
    logic                      seg_load;
    logic                      space;
    cib_pkg::ptr_result_t      ptr;
    logic [cib_pkg::SEG_W-1:0] seg;
    logic                      seg_rise;
    logic [31:0]               cur_seg_off;
    logic [31:0]               len_ext;
    cib_pkg::result_t          result;
    cib_pkg::result_t          out_data;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;
    assign byte_en     = accept && (in_ch.opcode == cib_pkg::OP_TABLE_BYTE);
    assign restart     = accept && (in_ch.opcode == cib_pkg::OP_RESTART);
    assign seg_load    = accept && (in_ch.opcode == cib_pkg::OP_LOAD_SEG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_bytes_reg <= 3'd3;
            segment_count_reg <= 5'd1;
            chunk_count_reg   <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cib_pkg::CFG_POINTER_BYTES: pointer_bytes_reg <= cfg_wdata[2:0];
                cib_pkg::CFG_SEGMENT_COUNT: segment_count_reg <= cfg_wdata[4:0];
                cib_pkg::CFG_CHUNK_COUNT:   chunk_count_reg   <= cfg_wdata[31:0];
                default:                    ;
            endcase
        end
    end

    cib_ptr_asm u_ptr_asm (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (byte_en),
        .restart       (restart),
        .table_byte    (in_ch.table_byte),
        .pointer_bytes (pointer_bytes_reg),
        .ptr           (ptr)
    );

    cib_seg_lookup u_seg_lookup (
        .clk           (clk),
        .wr_en         (seg_load),
        .wr_slot       (in_ch.seg_slot),
        .wr_first      (in_ch.seg_first_chunk),
        .wr_total      (in_ch.seg_chunk_total),
        .segment_count (segment_count_reg),
        .idx           (next_chunk_reg),
        .seg           (seg)
    );

    always_comb
    begin
        seg_rise    = seg > highest_reg;
        cur_seg_off = seg_rise ? 32'd0 : seg_off_reg;
        len_ext     = {2'b00, ptr.length};

        result.chunk_type     = ptr.ctype;
        result.chunk_length   = ptr.length;
        result.stream_offset  = run_off_reg;
        result.segment_offset = cur_seg_off;
        result.segment_number = seg;
        result.chunk_number   = next_chunk_reg;
        result.last_chunk     = next_chunk_reg == (chunk_count_reg - 32'd1);

        next_chunk_next = next_chunk_reg;
        run_off_next    = run_off_reg;
        seg_off_next    = seg_off_reg;
        highest_next    = highest_reg;
        if (restart)
        begin
            next_chunk_next = 32'd0;
            run_off_next    = 32'd0;
            seg_off_next    = 32'd0;
            highest_next    = '0;
        end
        else if (ptr.done)
        begin
            next_chunk_next = next_chunk_reg + 32'd1;
            run_off_next    = run_off_reg + len_ext;
            seg_off_next    = cur_seg_off + len_ext;
            highest_next    = seg_rise ? seg : highest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_chunk_reg <= 32'd0;
            run_off_reg    <= 32'd0;
            seg_off_reg    <= 32'd0;
            highest_reg    <= '0;
        end
        else
        begin
            next_chunk_reg <= next_chunk_next;
            run_off_reg    <= run_off_next;
            seg_off_reg    <= seg_off_next;
            highest_reg    <= highest_next;
        end
    end

    cib_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ptr.done),
        .push_data (result),
        .space     (space),
        .valid     (out_ch.valid),
        .ready     (out_ch.ready),
        .data      (out_data)
    );

    assign out_ch.chunk_type     = out_data.chunk_type;
    assign out_ch.chunk_length   = out_data.chunk_length;
    assign out_ch.stream_offset  = out_data.stream_offset;
    assign out_ch.segment_offset = out_data.segment_offset;
    assign out_ch.segment_number = out_data.segment_number;
    assign out_ch.chunk_number   = out_data.chunk_number;
    assign out_ch.last_chunk     = out_data.last_chunk;

    a_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        ptr.done |-> byte_en)
        else $error("entry produced without a table byte");

    a_chunk_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ptr.done |=> (next_chunk_reg == $past(next_chunk_reg) + 32'd1))
        else $error("chunk number did not advance");

    a_highest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(restart) |-> (highest_reg >= $past(highest_reg)))
        else $error("highest segment fell without a restart");

endmodule

`default_nettype wire
